@@ design/cidr_ban_table_core_defines.svh @@
// Assertion macros for the ban table checker.
// Used by design/cbt_checker.sv; no other dependencies.
`ifndef CIDR_BAN_TABLE_CORE_DEFINES_SVH
`define CIDR_BAN_TABLE_CORE_DEFINES_SVH
`define CBT_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("cbt check failed");
`define CBT_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("cbt check failed");
`endif

@@ design/cbt_pkg.sv @@
// Package for the ban table: types, constants, prefix helpers.
// No dependencies.
`default_nettype none
package cbt_pkg;
  localparam int Entries = 32;
  localparam int IdxW = $clog2(Entries);
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    REQ_CHECK = 2'd0, REQ_ADD = 2'd1, REQ_REMOVE = 2'd2, REQ_NONE = 2'd3
  } req_e;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_REFRESH = 2'd1;
  localparam logic [1:0] ST_ADDED = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_sec;
    logic        is_v6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  prefix_len;
    logic [15:0] duration_tenths;
  } in_t;

  typedef struct packed {
    logic       banned;
    logic [1:0] status;
    logic [5:0] removed_count;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] now;
    logic        v6;
    logic [63:0] ah;
    logic [63:0] al;
    logic [7:0]  plen;
    logic [31:0] expiry;
  } cmd_t;

  function automatic logic [127:0] pmask(input logic v6, input logic [7:0] plen);
    logic [127:0] m;
    m = '0;
    for (int b = 0; b < 128; b++)
      if (v6) m[127-b] = (8'(b) < plen);
      else if (b < 32) m[31-b] = (8'(b) < plen);
    return m;
  endfunction

  function automatic logic [7:0] norm_prefix(input logic v6, input logic [7:0] p);
    logic [7:0] full;
    full = v6 ? 8'd128 : 8'd32;
    return (p == 8'd0 || p > full) ? full : p;
  endfunction
endpackage
`default_nettype wire

@@ design/cbt_front.sv @@
// Front part: normalizes an item and computes its expiry, pushes into queue.
// Depends on cbt_pkg.
`default_nettype none
module cbt_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire cbt_pkg::in_t  req,
  input  wire logic          q_full,
  output logic               busy,
  output logic               push,
  output cbt_pkg::cmd_t      cmd
);
  logic        stg_v;
  cbt_pkg::in_t stg;
  logic [33:0] sum;
  logic [63:0] ah, al;

  assign busy = stg_v;
  always_ff @(posedge clk) begin
    if (rst) stg_v <= 1'b0;
    else if (start && !busy) begin
      stg_v <= 1'b1;
      stg <= req;
    end else if (push) stg_v <= 1'b0;
  end

  assign push = stg_v && !q_full;
  assign sum = 34'(stg.now_sec) + 34'({stg.duration_tenths, 2'b0}) +
               34'({stg.duration_tenths, 1'b0});
  assign ah = stg.is_v6 ? stg.addr_high : 64'd0;
  assign al = stg.is_v6 ? stg.addr_low : {32'd0, stg.addr_low[31:0]};
  always_comb begin
    cmd.req = stg.req_type;
    cmd.now = stg.now_sec;
    cmd.v6 = stg.is_v6;
    cmd.ah = ah;
    cmd.al = al;
    cmd.plen = cbt_pkg::norm_prefix(stg.is_v6, stg.prefix_len);
    if (stg.duration_tenths == 16'd0) cmd.expiry = 32'd0;
    else if (sum[33:32] != 2'b00) cmd.expiry = 32'hFFFF_FFFF;
    else cmd.expiry = sum[31:0];
  end
endmodule
`default_nettype wire

@@ design/cbt_queue.sv @@
// Short queue between front and back.
// Depends on cbt_pkg.
`default_nettype none
module cbt_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cbt_pkg::cmd_t din,
  input  wire logic          pop,
  output logic               full,
  output logic               empty,
  output cbt_pkg::cmd_t      dout
);
  cbt_pkg::cmd_t mem [cbt_pkg::QDepth];
  logic wp, rp;
  logic [1:0] cnt;
  assign full = (cnt == 2'(cbt_pkg::QDepth));
  assign empty = (cnt == 2'd0);
  assign dout = mem[rp];
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

@@ design/cbt_back.sv @@
// Back part: scans the table one entry a cycle and produces the result.
// Depends on cbt_pkg.
`default_nettype none
module cbt_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire cbt_pkg::cmd_t cmd,
  output logic               pop,
  output logic               idle,
  output logic               done,
  output cbt_pkg::out_t      result
);
  typedef enum logic [1:0] {S_IDLE, S_READ, S_SCAN, S_FIN} state_t;
  state_t state;
  cbt_pkg::cmd_t cur;
  logic [cbt_pkg::IdxW:0] idx;
  logic [cbt_pkg::Entries-1:0] used;
  logic        e_v6;
  logic [63:0] e_ah, e_al;
  logic [7:0]  e_plen;
  logic [31:0] e_exp;
  logic        m_v6 [cbt_pkg::Entries];
  logic [63:0] m_ah [cbt_pkg::Entries];
  logic [63:0] m_al [cbt_pkg::Entries];
  logic [7:0]  m_pl [cbt_pkg::Entries];
  logic [31:0] m_ex [cbt_pkg::Entries];
  logic [cbt_pkg::IdxW-1:0] ridx, eidx, claim_slot;
  logic have_free, hit, banned;
  logic [5:0] removed;
  logic wr_exp, wr_new, clr;
  logic [127:0] emask, cmask;
  logic chk_m, add_m, rem_m, e_used;

  assign ridx = idx[cbt_pkg::IdxW-1:0];
  always_ff @(posedge clk) begin
    e_v6 <= m_v6[ridx]; e_ah <= m_ah[ridx]; e_al <= m_al[ridx];
    e_plen <= m_pl[ridx]; e_exp <= m_ex[ridx];
    if (wr_exp) m_ex[eidx] <= cur.expiry;
    if (wr_new) begin
      m_v6[claim_slot] <= cur.v6; m_ah[claim_slot] <= cur.ah;
      m_al[claim_slot] <= cur.al; m_pl[claim_slot] <= cur.plen;
      m_ex[claim_slot] <= cur.expiry;
    end
  end

  assign e_used = used[eidx];
  assign emask = cbt_pkg::pmask(e_v6, e_plen);
  assign cmask = cbt_pkg::pmask(cur.v6, cur.plen);
  assign chk_m = e_used && (e_exp == 32'd0 || cur.now <= e_exp) && e_v6 == cur.v6 &&
                 ((({cur.ah, cur.al} ^ {e_ah, e_al}) & emask) == 128'd0);
  assign add_m = e_used && e_plen == cur.plen && e_v6 == cur.v6 &&
                 e_ah == cur.ah && e_al == cur.al;
  assign rem_m = e_used && e_plen >= cur.plen && e_v6 == cur.v6 &&
                 ((({cur.ah, cur.al} ^ {e_ah, e_al}) & cmask) == 128'd0);

  assign idle = (state == S_IDLE);
  assign pop = idle && !q_empty;
  assign wr_exp = state == S_SCAN && cur.req == cbt_pkg::REQ_ADD && !hit && add_m;
  assign wr_new = state == S_FIN && cur.req == cbt_pkg::REQ_ADD && !hit && have_free;
  assign clr = state == S_SCAN && cur.req == cbt_pkg::REQ_REMOVE && rem_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; used <= '0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (clr) used[eidx] <= 1'b0;
      if (wr_new) used[claim_slot] <= 1'b1;
      unique case (state)
        S_IDLE: if (pop) begin
          cur <= cmd; idx <= '0; hit <= 1'b0; banned <= 1'b0;
          have_free <= 1'b0; removed <= 6'd0; claim_slot <= '0;
          state <= S_READ;
        end
        S_READ: begin
          eidx <= ridx; idx <= idx + 1'b1; state <= S_SCAN;
        end
        S_SCAN: begin
          if (cur.req == cbt_pkg::REQ_CHECK && chk_m) banned <= 1'b1;
          if (wr_exp) hit <= 1'b1;
          if (cur.req == cbt_pkg::REQ_ADD && !hit && !add_m && !e_used && !have_free) begin
            have_free <= 1'b1; claim_slot <= eidx;
          end
          if (clr && removed != 6'd63) removed <= removed + 6'd1;
          eidx <= ridx;
          if (idx == (cbt_pkg::IdxW+1)'(cbt_pkg::Entries)) state <= S_FIN;
          else idx <= idx + 1'b1;
        end
        S_FIN: begin
          done <= 1'b1;
          result.banned <= (cur.req == cbt_pkg::REQ_CHECK) && banned;
          result.removed_count <= (cur.req == cbt_pkg::REQ_REMOVE) ? removed : 6'd0;
          if (cur.req != cbt_pkg::REQ_ADD) result.status <= cbt_pkg::ST_NONE;
          else if (hit) result.status <= cbt_pkg::ST_REFRESH;
          else if (have_free) result.status <= cbt_pkg::ST_ADDED;
          else result.status <= cbt_pkg::ST_FULL;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ design/cidr_ban_table_core.sv @@
// Top level of the prefix ban table: front, queue, back.
// Depends on cbt_pkg, cbt_front, cbt_queue, cbt_back.
//
// channel | signals            | handshake
// request | start, req, busy   | accepted when start && !busy
// result  | done, result       | one-cycle strobe, no back-pressure
//
// In the back scan a request steps through S_READ, S_SCAN and S_FIN, one entry read
// per cycle from the table memories; the front adds one staging register.
// Queue of two lets the front take items while the scan runs.
// Reset is synchronous and empties the table and queue.
`default_nettype none
module cidr_ban_table_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire cbt_pkg::in_t  req,
  output logic               busy,
  output logic               done,
  output cbt_pkg::out_t      result
);
  logic push, q_full, q_empty, pop, idle;
  cbt_pkg::cmd_t fcmd, qcmd;

  cbt_front u_front (.clk, .rst, .start, .req, .q_full, .busy, .push, .cmd(fcmd));
  cbt_queue u_queue (.clk, .rst, .push, .din(fcmd), .pop, .full(q_full),
                     .empty(q_empty), .dout(qcmd));
  cbt_back u_back (.clk, .rst, .q_empty, .cmd(qcmd), .pop, .idle, .done, .result);
endmodule
`default_nettype wire

@@ design/cbt_checker.sv @@
// Port-level checker for the ban table, bound to the top level.
// Depends on cbt_pkg and cidr_ban_table_core_defines.svh.
`default_nettype none
`include "cidr_ban_table_core_defines.svh"
module cbt_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         start,
  input wire logic         busy,
  input wire logic         done,
  input wire cbt_pkg::out_t result
);
  `CBT_ASSERT_NEXT(a_done_pulse, done, !done)
  `CBT_ASSERT_IMPL(a_status_add_only, done && result.status != cbt_pkg::ST_NONE,
                   !result.banned && result.removed_count == 6'd0)
  `CBT_ASSERT_IMPL(a_removed_range, done, result.removed_count <= 6'd32)
  `CBT_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
endmodule
bind cidr_ban_table_core cbt_checker u_chk (.clk, .rst, .start, .busy, .done, .result);
`default_nettype wire
